[design/dhcp_reply_option_parser_assert.svh]
// Assertion macros used by the DHCP reply option parser top level.
// Needs signals clk and arst_n in the scope of each use.
`ifndef DHCP_REPLY_OPTION_PARSER_ASSERT_SVH
`define DHCP_REPLY_OPTION_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define DRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define DRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/dhcp_rop_pkg.sv]
// Shared types, constants and helper functions of the DHCP reply option parser.
// No dependencies; imported by every module of the block.
package dhcp_rop_pkg;

	// DHCP field values
	localparam logic [7:0] OP_REPLY      = 8'h02;
	localparam logic [7:0] OPT_PAD       = 8'h00;
	localparam logic [7:0] OPT_MASK      = 8'h01;
	localparam logic [7:0] OPT_ROUTER    = 8'h03;
	localparam logic [7:0] OPT_TSERVER   = 8'h2a;
	localparam logic [7:0] OPT_LEASE     = 8'h33;
	localparam logic [7:0] OPT_RENEW     = 8'h3a;
	localparam logic [7:0] OPT_REBIND    = 8'h3b;
	localparam logic [7:0] OPT_MSG_TYPE  = 8'h35;
	localparam logic [7:0] OPT_END       = 8'hff;
	localparam logic [7:0] MSG_LEN_ONE   = 8'h01;
	localparam logic [7:0] MSG_OFFER     = 8'h02;
	localparam logic [7:0] MSG_ACK       = 8'h05;

	// Byte offsets within the payload
	localparam int OFF_OP       = 0;
	localparam int OFF_XID_LO   = 4;
	localparam int OFF_XID_HI   = 7;
	localparam int OFF_YIADDR_LO = 16;
	localparam int OFF_YIADDR_HI = 19;
	localparam int OFF_OPTIONS  = 240;

	// Lease value for a lease option of no value or over four bytes, and reset values
	localparam logic [31:0] LEASE_FALLBACK    = 32'd3600;
	localparam logic [31:0] XID_RESET         = 32'h17041989;
	localparam logic [31:0] LEASE_RESET       = 32'd3600;

	// Register indexes of the configuration port
	localparam logic REG_XID   = 1'b0;
	localparam logic REG_LEASE = 1'b1;

	// Result kind codes
	typedef enum logic [1:0] {
		KIND_IGNORED = 2'd0,
		KIND_OFFER   = 2'd1,
		KIND_ACK     = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	// Option walker state
	typedef enum logic [2:0] {
		PH_CODE   = 3'b001,
		PH_LENGTH = 3'b010,
		PH_VALUE  = 3'b100
	} phase_t;

	// Per-word control from the top level to the parsing units
	typedef struct packed {
		logic go;     // buffered word consumed this cycle
		logic clear;  // word is the last of its packet
	} step_ctl_t;

	// Result word, last field in the lowest bits
	typedef struct packed {
		logic [5:0]  prefix_length;
		logic [31:0] lease_seconds;
		logic [31:0] time_server_ip;
		logic [31:0] netmask;
		logic [31:0] gateway_addr;
		logic [31:0] your_addr;
		kind_t       kind;
	} result_t;

	// Count leading ones by binary search
	function automatic logic [5:0] leading_ones(input logic [31:0] v);
		logic [31:0] x;
		logic [5:0]  n;
		x = v;
		n = '0;
		if (x[31:16] == 16'hffff) begin
			n = n + 6'd16;
			x = x << 16;
		end
		if (x[31:24] == 8'hff) begin
			n = n + 6'd8;
			x = x << 8;
		end
		if (x[31:28] == 4'hf) begin
			n = n + 6'd4;
			x = x << 4;
		end
		if (x[31:30] == 2'b11) begin
			n = n + 6'd2;
			x = x << 2;
		end
		if (x[31]) begin
			n = n + 6'd1;
			x = x << 1;
		end
		if (x[31]) begin
			n = n + 6'd1;
		end
		return n;
	endfunction

endpackage

[design/dhcp_rop_hdr.sv]
// Fixed-header checker: byte offset, op and transaction id check, your-address
// capture and message-type classification. Depends on dhcp_rop_pkg.
module dhcp_rop_hdr
	import dhcp_rop_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  step_ctl_t   ctl,
	input  logic [7:0]  data_byte,
	input  logic [31:0] transaction_id,
	output logic        parse_en,
	output logic        in_options,
	output logic        hdr_ok_d,
	output logic [1:0]  msg_kind_d,
	output logic [31:0] offered_d
);

	localparam int OFF_W = $clog2(MAX_PAYLOAD_BYTES + 1);

	logic [OFF_W-1:0] offset_q;
	logic             hdr_ok_q;
	logic [1:0]       msg_kind_q;
	logic [31:0]      offered_q;
	logic [7:0]       xid_byte;

	// Bytes past the payload limit only count toward the last flag
	assign parse_en   = ctl.go && (offset_q < OFF_W'(MAX_PAYLOAD_BYTES));
	assign in_options = offset_q >= OFF_W'(OFF_OPTIONS);

	// Pick the expected id byte, big-endian over offsets 4 to 7
	always_comb begin
		unique case (offset_q[1:0])
			2'd0:    xid_byte = transaction_id[31:24];
			2'd1:    xid_byte = transaction_id[23:16];
			2'd2:    xid_byte = transaction_id[15:8];
			default: xid_byte = transaction_id[7:0];
		endcase
	end

	// Next header state for the buffered word
	always_comb begin
		hdr_ok_d   = hdr_ok_q;
		msg_kind_d = msg_kind_q;
		offered_d  = offered_q;
		if (parse_en) begin
			if (offset_q == OFF_W'(OFF_OP)) begin
				hdr_ok_d = (data_byte == OP_REPLY);
			end else if (offset_q >= OFF_W'(OFF_XID_LO) && offset_q <= OFF_W'(OFF_XID_HI)) begin
				if (data_byte != xid_byte) begin
					hdr_ok_d = 1'b0;
				end
			end else if (offset_q >= OFF_W'(OFF_YIADDR_LO) &&
				offset_q <= OFF_W'(OFF_YIADDR_HI)) begin
				offered_d = {offered_q[23:0], data_byte};
			end

			if (offset_q == OFF_W'(OFF_OPTIONS)) begin
				msg_kind_d = (data_byte == OPT_MSG_TYPE) ? KIND_IGNORED : KIND_OTHER;
			end else if (offset_q == OFF_W'(OFF_OPTIONS + 1)) begin
				if (msg_kind_q == KIND_IGNORED && data_byte != MSG_LEN_ONE) begin
					msg_kind_d = KIND_OTHER;
				end
			end else if (offset_q == OFF_W'(OFF_OPTIONS + 2)) begin
				if (msg_kind_q == KIND_IGNORED) begin
					if (data_byte == MSG_OFFER) begin
						msg_kind_d = KIND_OFFER;
					end else if (data_byte == MSG_ACK) begin
						msg_kind_d = KIND_ACK;
					end else begin
						msg_kind_d = KIND_OTHER;
					end
				end
			end
		end
	end

	// Advance the header state, clear it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			hdr_ok_q   <= 1'b1;
			msg_kind_q <= KIND_IGNORED;
			offered_q  <= '0;
		end else if (ctl.go && ctl.clear) begin
			offset_q   <= '0;
			hdr_ok_q   <= 1'b1;
			msg_kind_q <= KIND_IGNORED;
			offered_q  <= '0;
		end else if (parse_en) begin
			offset_q   <= offset_q + OFF_W'(1);
			hdr_ok_q   <= hdr_ok_d;
			msg_kind_q <= msg_kind_d;
			offered_q  <= offered_d;
		end
	end

endmodule

[design/dhcp_rop_opt.sv]
// Option walker: steps through code, length and value bytes up to the end
// marker and captures router, mask, time server and the lease minimum.
// Depends on dhcp_rop_pkg.
module dhcp_rop_opt
	import dhcp_rop_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  step_ctl_t   ctl,
	input  logic        parse_en,
	input  logic        in_options,
	input  logic [7:0]  data_byte,
	input  logic [31:0] default_lease,
	output logic [31:0] router_d,
	output logic [31:0] mask_d,
	output logic [31:0] tserver_d,
	output logic [31:0] lease_d
);

	phase_t      phase_q, phase_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  remain_q, remain_d;
	logic [7:0]  length_q, length_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] router_q, mask_q, tserver_q, lease_q;
	logic        end_q, end_d;

	logic        walk;
	logic        finish;
	logic [7:0]  fin_len;
	logic [7:0]  consumed;
	logic [31:0] fin_addr;
	logic [31:0] fin_lease;

	assign walk     = parse_en && in_options && !end_q;
	assign consumed = length_q - remain_q;

	// Walk one option byte
	always_comb begin
		phase_d  = phase_q;
		code_d   = code_q;
		remain_d = remain_q;
		length_d = length_q;
		acc_d    = acc_q;
		end_d    = end_q;
		finish   = 1'b0;
		if (walk) begin
			unique case (phase_q)
				PH_CODE: begin
					if (data_byte == OPT_END) begin
						end_d = 1'b1;
					end else if (data_byte != OPT_PAD) begin
						code_d  = data_byte;
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					length_d = data_byte;
					remain_d = data_byte;
					acc_d    = '0;
					if (data_byte == 8'd0) begin
						finish  = 1'b1;
						phase_d = PH_CODE;
					end else begin
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (consumed < 8'd4) begin
						acc_d = {acc_q[23:0], data_byte};
					end
					remain_d = remain_q - 8'd1;
					if (remain_q == 8'd1) begin
						finish  = 1'b1;
						phase_d = PH_CODE;
					end
				end
				default: begin
					phase_d = PH_CODE;
				end
			endcase
		end
	end

	// Align the value of a finished address option to the top bytes
	assign fin_len = length_d;
	always_comb begin
		priority if (fin_len == 8'd0) begin
			fin_addr = '0;
		end else if (fin_len == 8'd1) begin
			fin_addr = {acc_d[7:0], 24'd0};
		end else if (fin_len == 8'd2) begin
			fin_addr = {acc_d[15:0], 16'd0};
		end else if (fin_len == 8'd3) begin
			fin_addr = {acc_d[23:0], 8'd0};
		end else begin
			fin_addr = acc_d;
		end
	end

	assign fin_lease = (fin_len >= 8'd1 && fin_len <= 8'd4) ? acc_d : LEASE_FALLBACK;

	// Store the value of a finished option
	always_comb begin
		router_d  = router_q;
		mask_d    = mask_q;
		tserver_d = tserver_q;
		lease_d   = lease_q;
		if (finish) begin
			if (code_q == OPT_ROUTER) begin
				router_d = fin_addr;
			end else if (code_q == OPT_MASK) begin
				mask_d = fin_addr;
			end else if (code_q == OPT_TSERVER) begin
				tserver_d = fin_addr;
			end else if (code_q == OPT_LEASE || code_q == OPT_RENEW ||
				code_q == OPT_REBIND) begin
				if (fin_lease < lease_q) begin
					lease_d = fin_lease;
				end
			end
		end
	end

	// Hold or advance the walker, reset it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CODE;
			code_q    <= '0;
			remain_q  <= '0;
			length_q  <= '0;
			acc_q     <= '0;
			end_q     <= 1'b0;
			router_q  <= '0;
			mask_q    <= '0;
			tserver_q <= '0;
			lease_q   <= LEASE_RESET;
		end else if (ctl.go && ctl.clear) begin
			phase_q   <= PH_CODE;
			code_q    <= '0;
			remain_q  <= '0;
			length_q  <= '0;
			acc_q     <= '0;
			end_q     <= 1'b0;
			router_q  <= '0;
			mask_q    <= '0;
			tserver_q <= '0;
			lease_q   <= default_lease;
		end else if (walk) begin
			phase_q   <= phase_d;
			code_q    <= code_d;
			remain_q  <= remain_d;
			length_q  <= length_d;
			acc_q     <= acc_d;
			end_q     <= end_d;
			router_q  <= router_d;
			mask_q    <= mask_d;
			tserver_q <= tserver_d;
			lease_q   <= lease_d;
		end
	end

endmodule

[design/dhcp_reply_option_parser.sv]
// DHCP reply option parser, top level: input buffer, result register and
// configuration registers. Depends on dhcp_rop_pkg, dhcp_rop_hdr, dhcp_rop_opt.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid/tready             tdata[7:0] data_byte, tlast last
// m_axis    out  tvalid/tready             tdata[167:0] result word
// apb       in   psel/penable/pready       transaction_id @0x0, default_lease @0x4
//
// One payload byte is taken every cycle; each byte is registered in the input
// buffer and a packet's result is loaded when its last byte leaves the buffer.
// Only a last byte waits, and only while the result register still holds an
// untaken result. Reset is asynchronous and leaves both sides empty.
`include "dhcp_reply_option_parser_assert.svh"

module dhcp_reply_option_parser
	import dhcp_rop_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [1:0] kind, [33:2] your_addr, [65:34] gateway_addr, [97:66] netmask,
	// [129:98] time_server_ip, [161:130] lease_seconds, [167:162] prefix_length
	output logic [167:0]  m_axis_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic [31:0] xid_q;
	logic [31:0] lease_cfg_q;

	step_ctl_t   ctl;
	logic        parse_en, in_options;
	logic        hdr_ok_d;
	logic [1:0]  msg_kind_d;
	logic [31:0] offered_d, router_d, mask_d, tserver_d, lease_d;
	result_t     res;
	kind_t       kind_res;

	// Consume the buffered word unless it ends a packet and the result is stuck
	assign ctl.go        = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign ctl.clear     = last_s1;
	assign s_axis_tready = !valid_s1 || ctl.go;

	// Input buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	dhcp_rop_hdr #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_hdr (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.data_byte     (byte_s1),
		.transaction_id(xid_q),
		.parse_en      (parse_en),
		.in_options    (in_options),
		.hdr_ok_d      (hdr_ok_d),
		.msg_kind_d    (msg_kind_d),
		.offered_d     (offered_d)
	);

	dhcp_rop_opt u_opt (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.parse_en     (parse_en),
		.in_options   (in_options),
		.data_byte    (byte_s1),
		.default_lease(lease_cfg_q),
		.router_d     (router_d),
		.mask_d       (mask_d),
		.tserver_d    (tserver_d),
		.lease_d      (lease_d)
	);

	// Build the result word from the updated packet state
	assign kind_res = (msg_kind_d == KIND_IGNORED) ? KIND_OTHER : kind_t'(msg_kind_d);
	always_comb begin
		res = '0;
		if (hdr_ok_d) begin
			res.kind       = kind_res;
			res.your_addr  = offered_d;
			if (kind_res == KIND_ACK) begin
				res.gateway_addr   = router_d;
				res.netmask        = mask_d;
				res.time_server_ip = tserver_d;
				res.lease_seconds  = (lease_d < lease_cfg_q) ? lease_d : lease_cfg_q;
				res.prefix_length  = leading_ones(mask_d);
			end
		end
	end

	// Result register: load on a consumed last word, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.go && ctl.clear) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go && ctl.clear) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xid_q       <= XID_RESET;
			lease_cfg_q <= LEASE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_XID:   xid_q       <= pwdata;
				REG_LEASE: lease_cfg_q <= pwdata;
				default:   xid_q       <= xid_q;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LEASE) ? lease_cfg_q : xid_q;

	// Checks on the block's own handshake logic and result fields
	`DRP_ASSERT_NEXT(a_result_follows_last, ctl.go && ctl.clear, out_valid_q,
		"consumed last word did not load a result")
	`DRP_ASSERT_NOW(a_last_waits_on_stall, valid_s1 && last_s1 && out_valid_q && !m_axis_tready,
		!ctl.go, "last word consumed while result register was stalled")
	`DRP_ASSERT_NOW(a_ignored_is_empty, out_valid_q && out_q.kind == KIND_IGNORED,
		out_q.your_addr == 32'd0 && out_q.lease_seconds == 32'd0,
		"ignored packet carries nonzero fields")
	`DRP_ASSERT_NOW(a_non_ack_no_options, out_valid_q && out_q.kind != KIND_ACK,
		out_q.gateway_addr == 32'd0 && out_q.prefix_length == 6'd0,
		"non-ack result carries option values")

endmodule

[test/tb_dhcp_reply_option_parser.sv]
// Testbench for the DHCP reply option parser: streams full and truncated payloads
// byte by byte and checks every result word against a predictor of its own.
// Depends on dhcp_rop_pkg and the dhcp_reply_option_parser top level.
`timescale 1ns / 1ps

module tb_dhcp_reply_option_parser;
	import dhcp_rop_pkg::*;

	localparam int PAYLOAD_LIMIT = 1024;
	localparam int LONG_HOLD     = 300;

	// Slots of the captured address table
	localparam int SLOT_YIADDR  = 0;
	localparam int SLOT_ROUTER  = 1;
	localparam int SLOT_MASK    = 2;
	localparam int SLOT_TSERVER = 3;

	// Packet tracker: follows the parse of each accepted word and holds the
	// result words still due from the block
	class dhcp_reply_tracker;
		logic [31:0] xid;
		logic [31:0] dflt_lease;
		int          offset;
		bit          hdr_ok;
		kind_t       msg_kind;   // KIND_IGNORED here means type not yet known
		phase_t      walk_phase;
		logic [7:0]  opt_code;
		logic [7:0]  opt_left;
		logic [7:0]  opt_len;
		logic [31:0] acc;
		logic [31:0] addrs [4];
		logic [31:0] lease_min;
		bit          end_seen;
		result_t     replies_due [$];
		int          errors;

		function new();
			xid = XID_RESET;
			dflt_lease = LEASE_RESET;
			errors = 0;
			clear_packet();
		endfunction

		function void set_register(logic idx, logic [31:0] v);
			if (idx == REG_XID)
				xid = v;
			else
				dflt_lease = v;
		endfunction

		function int outstanding();
			return replies_due.size();
		endfunction

		function void clear_packet();
			offset = 0;
			hdr_ok = 1'b1;
			msg_kind = KIND_IGNORED;
			walk_phase = PH_CODE;
			opt_code = '0;
			opt_left = '0;
			opt_len = '0;
			acc = '0;
			foreach (addrs[i])
				addrs[i] = '0;
			lease_min = dflt_lease;
			end_seen = 1'b0;
		endfunction

		// Store a completed option: addresses left-aligned, leases into the minimum
		function void close_option();
			int n;
			logic [31:0] addr;
			logic [31:0] lt;
			n = (opt_len < 4) ? opt_len : 4;
			addr = (n == 0) ? 32'h0 : acc << (8 * (4 - n));
			if (opt_code == OPT_ROUTER)
				addrs[SLOT_ROUTER] = addr;
			else if (opt_code == OPT_MASK)
				addrs[SLOT_MASK] = addr;
			else if (opt_code == OPT_TSERVER)
				addrs[SLOT_TSERVER] = addr;
			else if (opt_code == OPT_LEASE || opt_code == OPT_RENEW || opt_code == OPT_REBIND) begin
				lt = (opt_len >= 1 && opt_len <= 4) ? acc : LEASE_FALLBACK;
				if (lt < lease_min)
					lease_min = lt;
			end
		endfunction

		function void walk_option(logic [7:0] b);
			case (walk_phase)
			PH_CODE: begin
				if (b == OPT_END)
					end_seen = 1'b1;
				else if (b != OPT_PAD) begin
					opt_code = b;
					walk_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				opt_len = b;
				opt_left = b;
				acc = '0;
				if (b == 8'h00) begin
					close_option();
					walk_phase = PH_CODE;
				end else begin
					walk_phase = PH_VALUE;
				end
			end
			default: begin
				// keep only the first four value bytes
				if (int'(opt_len) - int'(opt_left) < 4)
					acc = {acc[23:0], b};
				opt_left = opt_left - 8'd1;
				if (opt_left == 8'h00) begin
					close_option();
					walk_phase = PH_CODE;
				end
			end
			endcase
		endfunction

		function void take_word(int off, logic [7:0] b);
			logic [7:0] want;
			if (off == OFF_OP)
				hdr_ok = (b == OP_REPLY);
			else if (off >= OFF_XID_LO && off <= OFF_XID_HI) begin
				want = 8'(xid >> (8 * (OFF_XID_HI - off)));
				if (want != b)
					hdr_ok = 1'b0;
			end else if (off >= OFF_YIADDR_LO && off <= OFF_YIADDR_HI)
				addrs[SLOT_YIADDR] = {addrs[SLOT_YIADDR][23:0], b};

			// message type option must open the option area
			if (off == OFF_OPTIONS)
				msg_kind = (b == OPT_MSG_TYPE) ? KIND_IGNORED : KIND_OTHER;
			else if (off == OFF_OPTIONS + 1) begin
				if (msg_kind == KIND_IGNORED && b != MSG_LEN_ONE)
					msg_kind = KIND_OTHER;
			end else if (off == OFF_OPTIONS + 2) begin
				if (msg_kind == KIND_IGNORED)
					msg_kind = (b == MSG_OFFER) ? KIND_OFFER :
						(b == MSG_ACK) ? KIND_ACK : KIND_OTHER;
			end

			if (off >= OFF_OPTIONS && !end_seen)
				walk_option(b);
		endfunction

		function logic [5:0] count_leading_ones(logic [31:0] v);
			int n;
			n = 0;
			while (n < 32 && v[31 - n])
				n++;
			return 6'(n);
		endfunction

		// Advance on one accepted input word; a last word closes the packet
		function void note_byte(logic [7:0] b, logic is_last);
			result_t r;
			if (offset < PAYLOAD_LIMIT) begin
				take_word(offset, b);
				offset++;
			end
			if (!is_last)
				return;
			r = '0;
			if (hdr_ok) begin
				r.kind = (msg_kind == KIND_IGNORED) ? KIND_OTHER : msg_kind;
				r.your_addr = addrs[SLOT_YIADDR];
				if (r.kind == KIND_ACK) begin
					r.gateway_addr = addrs[SLOT_ROUTER];
					r.netmask = addrs[SLOT_MASK];
					r.time_server_ip = addrs[SLOT_TSERVER];
					r.lease_seconds = (lease_min < dflt_lease) ? lease_min : dflt_lease;
					r.prefix_length = count_leading_ones(addrs[SLOT_MASK]);
				end
			end
			replies_due.push_back(r);
			clear_packet();
		endfunction

		function void check_reply(result_t got);
			result_t want;
			if (replies_due.size() == 0) begin
				$error("result word with none due: kind %0d your_addr %h", got.kind,
					got.your_addr);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.your_addr !== want.your_addr) begin
				$error("your_addr: expected %h, got %h", want.your_addr, got.your_addr);
				errors++;
			end
			if (got.gateway_addr !== want.gateway_addr) begin
				$error("gateway_addr: expected %h, got %h", want.gateway_addr,
					got.gateway_addr);
				errors++;
			end
			if (got.netmask !== want.netmask) begin
				$error("netmask: expected %h, got %h", want.netmask, got.netmask);
				errors++;
			end
			if (got.time_server_ip !== want.time_server_ip) begin
				$error("time_server_ip: expected %h, got %h", want.time_server_ip,
					got.time_server_ip);
				errors++;
			end
			if (got.lease_seconds !== want.lease_seconds) begin
				$error("lease_seconds: expected %h, got %h", want.lease_seconds,
					got.lease_seconds);
				errors++;
			end
			if (got.prefix_length !== want.prefix_length) begin
				$error("prefix_length: expected %0d, got %0d", want.prefix_length,
					got.prefix_length);
				errors++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [7:0]    s_axis_tdata;   // [7:0] data_byte
	logic          s_axis_tlast;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	// [1:0] kind, [33:2] your_addr, [65:34] gateway_addr, [97:66] netmask,
	// [129:98] time_server_ip, [161:130] lease_seconds, [167:162] prefix_length
	logic [167:0]  m_axis_tdata;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [2:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	dhcp_reply_tracker tracker = new();

	logic [7:0] pkt_bytes [$];
	bit         offering;
	bit         sender_gaps;
	bit         rx_stalls;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;

	dhcp_reply_option_parser #(
		.MAX_PAYLOAD_BYTES(PAYLOAD_LIMIT)
	) DUT (.*);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check accepted words, stall in bursts or for one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_reply(m_axis_tdata);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end else if (hold_left == 0 && rx_stalls && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 10);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one word and hold it until taken, then maybe drop valid for a while
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.note_byte(b, is_last);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
	endtask

	// Drop valid and wait until every due result word has been taken
	task automatic settle();
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tracker.set_register(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Fixed header up to the option area, random where the parser does not look
	function automatic void start_header(bit is_reply, bit id_ok);
		logic [31:0] id;
		logic [7:0]  b;
		int i;
		pkt_bytes.delete();
		id = tracker.xid;
		if (!id_ok)
			id = id ^ (32'h1 << $urandom_range(0, 31));
		for (i = 0; i < OFF_OPTIONS; i++) begin
			b = 8'($urandom);
			if (i == OFF_OP)
				b = is_reply ? OP_REPLY : ((b == OP_REPLY) ? 8'h01 : b);
			else if (i >= OFF_XID_LO && i <= OFF_XID_HI)
				b = 8'(id >> (8 * (OFF_XID_HI - i)));
			pkt_bytes.push_back(b);
		end
	endfunction

	function automatic void trim_packet(int n);
		while (pkt_bytes.size() > n)
			void'(pkt_bytes.pop_back());
	endfunction

	// Value bytes big-endian from the low end of v, random beyond four
	function automatic void add_option(logic [7:0] code, int len, logic [31:0] v);
		int k;
		int i;
		logic [7:0] b;
		k = (len < 4) ? len : 4;
		pkt_bytes.push_back(code);
		pkt_bytes.push_back(len[7:0]);
		for (i = 0; i < len; i++) begin
			if (i < k)
				b = 8'(v >> (8 * (k - 1 - i)));
			else
				b = 8'($urandom);
			pkt_bytes.push_back(b);
		end
	endfunction

	function automatic void end_options(int trailing);
		pkt_bytes.push_back(OPT_END);
		repeat (trailing) pkt_bytes.push_back(8'($urandom));
	endfunction

	// Header-only packets of random length: op and id checks, short replies
	function automatic void build_short_packet();
		start_header($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
		trim_packet($urandom_range(1, 12));
	endfunction

	task automatic run_random(input int count);
		repeat (count) begin
			build_short_packet();
			send_packet();
		end
	endtask

	// Stimulus
	initial begin
		logic [31:0] xid_set [4];
		logic [31:0] lease_set [4];
		int ph;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		offering = 1'b0;
		sender_gaps = 1'b1;
		rx_stalls = 1'b1;
		xid_set = '{$urandom, 32'hffffffff, 32'h0, XID_RESET};
		lease_set = '{32'h0, 32'hffffffff, $urandom_range(1, 8000), $urandom};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ack: pads, short and long values, lease fallbacks, repeats, bytes after end
		start_header(1, 1);
		add_option(OPT_MSG_TYPE, 1, MSG_ACK);
		pkt_bytes.push_back(OPT_PAD);
		pkt_bytes.push_back(OPT_PAD);
		add_option(OPT_ROUTER, 2, 32'hbeef);
		add_option(OPT_ROUTER, 6, $urandom);
		add_option(OPT_TSERVER, 0, 32'h0);
		add_option(OPT_TSERVER, 3, 32'h0a0001);
		add_option(OPT_MASK, 4, 32'hffffff00);
		add_option(OPT_LEASE, 2, 32'd900);
		add_option(OPT_RENEW, 6, 32'h0);
		add_option(OPT_REBIND, 0, 32'h0);
		add_option(OPT_LEASE, 4, 32'd1800);
		add_option(8'h0c, 5, $urandom);
		end_options(0);
		add_option(OPT_LEASE, 4, 32'd1);
		send_packet();

		// packets that end before the message type is known
		start_header(1, 1);
		trim_packet(20);
		send_packet();
		start_header(1, 1);
		trim_packet(1);
		send_packet();

		// request op, wrong transaction id
		start_header(0, 1);
		trim_packet(8);
		send_packet();
		start_header(1, 0);
		trim_packet(8);
		send_packet();

		run_random(3);

		for (ph = 0; ph < 4; ph++) begin
			settle();
			apb_write(REG_XID, xid_set[ph]);
			apb_write(REG_LEASE, lease_set[ph]);
			if (ph == 0) begin
				// long receiver hold while short packets pile up behind it
				hold_requests++;
				while (hold_served != hold_requests)
					@(posedge clk);
				repeat (8) begin
					start_header(1, $urandom_range(0, 1));
					trim_packet($urandom_range(1, 6));
					send_packet();
				end
				settle();
			end
			if (ph == 3) begin
				sender_gaps = 1'b0;
				rx_stalls = 1'b0;
			end
			run_random(4);
		end

		settle();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("** dhcp_reply_option_parser: PASSED **");
		else
			$display("** dhcp_reply_option_parser: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("** dhcp_reply_option_parser: FAILED **");
		$finish;
	end

endmodule
